[src/pad_pkg.sv]
`timescale 1ns / 1ps
// Shared types and constants for the PWM angle decoder.
package pad_pkg;

    // Field widths of the ports
    localparam int TIME_W  = 32;
    localparam int ANGLE_W = 16;

    // One full turn in hundredths of a degree
    localparam int FULL_TURN_CENTI = 36000;

    // Reset value of the zero offset register
    localparam logic [ANGLE_W-1:0] OFFSET_RESET = 16'd13800;

    typedef enum logic [2:0] {
        S_IDLE,
        S_MUL,
        S_DIV,
        S_RECIP,
        S_FIN
    } t_state;

endpackage

[src/pwm_angle_decoder.sv]
`timescale 1ns / 1ps
// PWM angle decoder: edge timestamps in, angle / high time / period out.
// Sequence: an accepted capture steps through S_MUL, S_DIV, S_RECIP and S_FIN
//   into the output register (QW = 28 quotient bits at the default parameters);
//   an invalid measurement goes from S_MUL straight to S_FIN. A new capture is
//   taken only in S_IDLE, after S_FIN has written the result; S_FIN waits while
//   the output slot is full; the radix-2 divider retires one quotient bit a cycle.
// Reset (synchronous, active low): clears edge tracking, period, high time, ready
//   flag and the output slot; the zero offset returns to 13800.
module pwm_angle_decoder #(
    parameter int COUNTER_WIDTH = 32,
    parameter int RESOLUTION    = 4098
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    // Config
    input  logic                          i_cfg_we,
    input  logic [pad_pkg::ANGLE_W-1:0]   i_cfg_wdata,
    // Capture channel
    input  logic                          i_in_valid,
    output logic                          o_in_ready,
    input  logic [pad_pkg::TIME_W-1:0]    i_capture_time,
    // Result channel
    output logic                          o_out_valid,
    input  logic                          i_out_ready,
    output logic [pad_pkg::ANGLE_W-1:0]   o_angle_centi,
    output logic [pad_pkg::TIME_W-1:0]    o_high_count,
    output logic [pad_pkg::TIME_W-1:0]    o_period_count,
    output logic                          o_ready_res
);
    import pad_pkg::*;

    localparam int CW = COUNTER_WIDTH;

    // t = floor(high * SCALE / period) never exceeds SCALE, so QW bits hold it.
    localparam logic [63:0] SCALE = 64'(RESOLUTION) * 64'(FULL_TURN_CENTI);
    localparam int QW   = $clog2(SCALE + 64'd1);
    localparam int L    = $clog2(RESOLUTION);
    // Reciprocal for exact floor(x / RESOLUTION) with x < 2^QW:
    // m = ceil(2^(QW+L) / RESOLUTION), fits in QW+1 bits.
    localparam logic [63:0] RECIP =
        ((64'd1 << (QW + L)) + 64'(RESOLUTION) - 64'd1) / 64'(RESOLUTION);
    localparam int AW   = (CW > QW) ? CW : QW;
    localparam int BW   = QW + 1;
    localparam int PW   = AW + BW;
    localparam int CNTW = $clog2(QW);

    localparam logic [BW-1:0] SCALE_B = SCALE[BW-1:0];
    localparam logic [BW-1:0] RECIP_B = RECIP[BW-1:0];
    localparam logic [QW-1:0] TURN_Q  = QW'(FULL_TURN_CENTI);
    // 36000 + RESOLUTION - 1: numerator of the ceiling on the negative side
    localparam logic [QW-1:0] NEG_BIAS = QW'(FULL_TURN_CENTI + RESOLUTION - 1);
    localparam logic signed [18:0] TURN_S = 19'sd36000;

    // ---------------- Control and tracking state ----------------
    t_state r_state, n_state;

    logic [ANGLE_W-1:0] r_offset;
    logic [CW-1:0]      r_last_rise;
    logic               r_have_rise;
    logic               r_waiting_fall;
    logic [CW-1:0]      r_period;
    logic [CW-1:0]      r_high;
    logic               r_ready_flag;

    // ---------------- Datapath registers ----------------
    logic [CW-1:0]      r_rem;      // running remainder, always < period
    logic [QW-1:0]      r_quo;      // dividend low bits shift out, quotient shifts in
    logic [CNTW-1:0]    r_cnt;
    logic               r_invalid;
    logic               r_neg;      // raw angle is negative
    logic [ANGLE_W-1:0] r_mag;      // |raw angle|

    logic               r_out_valid;
    logic [ANGLE_W-1:0] r_angle;
    logic [CW-1:0]      r_out_high;
    logic [CW-1:0]      r_out_period;
    logic               r_out_ready;

    logic in_take;
    logic out_free;

    assign in_take  = i_in_valid && o_in_ready;
    assign out_free = !r_out_valid || i_out_ready;

    // ---------------- Shared multiplier ----------------
    // Pass 1: high * SCALE. Pass 2: x * RECIP for the divide by RESOLUTION.
    logic [AW-1:0] mul_a;
    logic [BW-1:0] mul_b;
    logic [PW-1:0] mul_p;
    logic [QW-1:0] t_x;
    logic          t_neg;
    logic [PW-1:0] p_shift;

    always_comb begin
        t_neg = (r_quo < TURN_Q);
        t_x   = t_neg ? (NEG_BIAS - r_quo) : (r_quo - TURN_Q);
        if (r_state == S_MUL) begin
            mul_a = AW'(r_high);
            mul_b = SCALE_B;
        end else begin
            mul_a = AW'(t_x);
            mul_b = RECIP_B;
        end
        mul_p   = PW'(mul_a) * PW'(mul_b);
        p_shift = mul_p >> (QW + L);
    end

    // ---------------- Restoring divide step ----------------
    logic [CW:0]   div_rs;
    logic [CW:0]   div_diff;
    logic          div_ge;

    always_comb begin
        div_rs   = {r_rem, r_quo[QW-1]};
        div_ge   = (div_rs >= {1'b0, r_period});
        div_diff = div_rs - {1'b0, r_period};
    end

    // ---------------- Offset and wrap ----------------
    logic signed [18:0] raw_s;
    logic signed [18:0] wrap0;
    logic signed [18:0] wrap1;
    logic signed [18:0] wrap2;

    always_comb begin
        raw_s = $signed({3'b000, r_mag});
        if (r_neg) begin
            raw_s = -raw_s;
        end
        wrap0 = raw_s - $signed({3'b000, r_offset});
        wrap1 = (wrap0 < 0) ? (wrap0 + TURN_S) : wrap0;
        wrap2 = (wrap1 < 0) ? (wrap1 + TURN_S) : wrap1;
    end

    // ---------------- Sequencer ----------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state    = r_state;
        o_in_ready = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    n_state = S_MUL;
                end
            end
            S_MUL: begin
                // Zero period or high beyond period: skip the math, angle is 0
                if ((r_period == '0) || (r_high > r_period)) begin
                    n_state = S_FIN;
                end else begin
                    n_state = S_DIV;
                end
            end
            S_DIV: begin
                if (r_cnt == '0) begin
                    n_state = S_RECIP;
                end
            end
            S_RECIP: begin
                n_state = S_FIN;
            end
            S_FIN: begin
                if (out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // ---------------- Edge tracking and config ----------------
    logic [CW-1:0] cap;
    logic [CW-1:0] delta;

    assign cap   = i_capture_time[CW-1:0];
    assign delta = cap - r_last_rise;   // wraps mod 2^CW

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_offset       <= OFFSET_RESET;
            r_last_rise    <= '0;
            r_have_rise    <= 1'b0;
            r_waiting_fall <= 1'b0;
            r_period       <= '0;
            r_high         <= '0;
            r_ready_flag   <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_offset <= i_cfg_wdata;
            end
            if (in_take) begin
                if (r_waiting_fall) begin
                    r_high         <= delta;
                    r_waiting_fall <= 1'b0;
                    r_ready_flag   <= (r_period != '0);
                end else begin
                    // First rise after reset only records the timestamp
                    if (r_have_rise) begin
                        r_period <= delta;
                    end
                    r_last_rise    <= cap;
                    r_have_rise    <= 1'b1;
                    r_waiting_fall <= 1'b1;
                end
            end
        end
    end

    // ---------------- Datapath ----------------
    always_ff @(posedge i_clk) begin
        unique case (r_state)
            S_MUL: begin
                r_invalid <= (r_period == '0) || (r_high > r_period);
                // Top CW bits of the product start the remainder (< period)
                r_rem     <= mul_p[QW +: CW];
                r_quo     <= mul_p[QW-1:0];
                r_cnt     <= CNTW'(QW - 1);
            end
            S_DIV: begin
                r_rem <= div_ge ? div_diff[CW-1:0] : div_rs[CW-1:0];
                r_quo <= {r_quo[QW-2:0], div_ge};
                r_cnt <= r_cnt - 1'b1;
            end
            S_RECIP: begin
                r_neg <= t_neg;
                r_mag <= p_shift[ANGLE_W-1:0];
            end
            S_IDLE, S_FIN: begin
            end
            default: begin
            end
        endcase
    end

    // ---------------- Output register ----------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if ((r_state == S_FIN) && out_free) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if ((r_state == S_FIN) && out_free) begin
            r_angle      <= r_invalid ? '0 : wrap2[ANGLE_W-1:0];
            r_out_high   <= r_high;
            r_out_period <= r_period;
            r_out_ready  <= r_ready_flag;
        end
    end

    assign o_out_valid    = r_out_valid;
    assign o_angle_centi  = r_angle;
    assign o_high_count   = TIME_W'(r_out_high);
    assign o_period_count = TIME_W'(r_out_period);
    assign o_ready_res    = r_out_ready;

    // ---------------- Assertions ----------------
    a_take_starts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_take |=> (r_state == S_MUL) && !o_in_ready)
        else $error("accepted transaction did not start the sequencer");

    a_edge_toggle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_take |=> (r_waiting_fall != $past(r_waiting_fall)))
        else $error("edge polarity tracking did not alternate");

    a_rem_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DIV) |-> (r_rem < r_period))
        else $error("divider remainder not below period");

    a_angle_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_angle_centi < ANGLE_W'(FULL_TURN_CENTI)))
        else $error("angle out of range");

endmodule

[tb/pwm_angle_decoder_tb.sv]
`timescale 1ns / 1ps
// Self-checking testbench for the PWM angle decoder: edge captures in, angle readings checked.
module pwm_angle_decoder_tb;

    import pad_pkg::*;

    // Block parameters used by the instance and the predictor
    localparam int COUNTER_WIDTH = 32;
    localparam int RESOLUTION    = 4098;
    // Capture-to-result latency assumed by the bench when draining
    localparam int LATENCY       = 31;

    localparam longint unsigned FULL_TURN = FULL_TURN_CENTI;
    localparam longint unsigned SCALE     = 64'(RESOLUTION) * FULL_TURN;

    // Directed edge sequence, rise / fall alternating from reset:
    // first rise, fall with no period yet, zero high time, high equal to period,
    // high past period, zero period, timer wrap, all-zeros / all-ones captures.
    localparam logic [TIME_W-1:0] DIRECTED_CAPS [22] = '{
        32'd1000,       32'd1500,
        32'd11000,      32'd11000,
        32'd21000,      32'd31000,
        32'd31000,      32'd51000,
        32'd51000,      32'd51001,
        32'd51000,      32'd51005,
        32'hFFFF_FF00,  32'h0000_0100,
        32'h0000_0800,  32'h0000_0C00,
        32'h0000_0000,  32'hFFFF_FFFF,
        32'hFFFF_FFFF,  32'hFFFF_FFFE,
        32'hAAAA_AAAA,  32'h5555_5555
    };

    // One result transaction: angle, high time, period, ready flag
    typedef struct {
        logic [ANGLE_W-1:0] angle;
        logic [TIME_W-1:0]  high_ticks;
        logic [TIME_W-1:0]  period_ticks;
        logic               ready;
    } t_pwm_reading;

    // Tracks the edge state of the decoder and holds the readings still owed
    class angle_scoreboard;
        logic [TIME_W-1:0]  last_rise;
        logic               have_rise;
        logic               waiting_fall;
        logic [TIME_W-1:0]  period_ticks;
        logic [TIME_W-1:0]  high_ticks;
        logic               ready;
        logic [ANGLE_W-1:0] offset;
        t_pwm_reading       owed_readings[$];
        int unsigned        mismatches;

        function new();
            last_rise    = '0;
            have_rise    = 1'b0;
            waiting_fall = 1'b0;
            period_ticks = '0;
            high_ticks   = '0;
            ready        = 1'b0;
            offset       = OFFSET_RESET;
            mismatches   = 0;
        endfunction

        function void set_offset(logic [ANGLE_W-1:0] value);
            offset = value;
        endfunction

        function int unsigned pending();
            return owed_readings.size();
        endfunction

        // Angle in centidegrees from the current high time and period
        function logic [ANGLE_W-1:0] predict_angle();
            longint unsigned t;
            longint          raw;
            longint          wrapped;
            if (period_ticks == 0 || high_ticks > period_ticks) begin
                return '0;
            end
            t = (64'(high_ticks) * SCALE) / 64'(period_ticks);
            // floor division: negative offsets round toward minus infinity
            if (t >= FULL_TURN) begin
                raw = longint'((t - FULL_TURN) / RESOLUTION);
            end else begin
                raw = -longint'((FULL_TURN - t + RESOLUTION - 1) / RESOLUTION);
            end
            wrapped = (raw - longint'(offset)) % longint'(FULL_TURN);
            if (wrapped < 0) begin
                wrapped += longint'(FULL_TURN);
            end
            return ANGLE_W'(wrapped);
        endfunction

        function void note_capture(logic [TIME_W-1:0] cap);
            t_pwm_reading owed;
            if (waiting_fall) begin
                high_ticks   = cap - last_rise;
                waiting_fall = 1'b0;
                ready        = (period_ticks != 0);
            end else begin
                // first rise after reset only stores the timestamp
                if (have_rise) begin
                    period_ticks = cap - last_rise;
                end
                last_rise    = cap;
                have_rise    = 1'b1;
                waiting_fall = 1'b1;
            end
            owed.angle        = predict_angle();
            owed.high_ticks   = high_ticks;
            owed.period_ticks = period_ticks;
            owed.ready        = ready;
            owed_readings.push_back(owed);
        endfunction

        function void check_result(logic [ANGLE_W-1:0] angle, logic [TIME_W-1:0] high_cnt,
                                   logic [TIME_W-1:0] period_cnt, logic ready_res);
            t_pwm_reading want;
            if (owed_readings.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) begin
                    $display("%0t: unexpected result angle=%0d high=%0d period=%0d ready=%0b",
                             $realtime, angle, high_cnt, period_cnt, ready_res);
                end
                return;
            end
            want = owed_readings.pop_front();
            if (angle !== want.angle || high_cnt !== want.high_ticks ||
                    period_cnt !== want.period_ticks || ready_res !== want.ready) begin
                mismatches++;
                if (mismatches <= 10) begin
                    $display("%0t: mismatch exp angle=%0d high=%0d period=%0d ready=%0b",
                             $realtime, want.angle, want.high_ticks, want.period_ticks,
                             want.ready);
                    $display("%0t:          got angle=%0d high=%0d period=%0d ready=%0b",
                             $realtime, angle, high_cnt, period_cnt, ready_res);
                end
            end
        endfunction
    endclass

    logic                i_clk = 1'b0;
    logic                i_rst_n;
    logic                i_cfg_we;
    logic [ANGLE_W-1:0]  i_cfg_wdata;
    logic                i_in_valid;
    logic                o_in_ready;
    logic [TIME_W-1:0]   i_capture_time;
    logic                o_out_valid;
    logic                i_out_ready;
    logic [ANGLE_W-1:0]  o_angle_centi;
    logic [TIME_W-1:0]   o_high_count;
    logic [TIME_W-1:0]   o_period_count;
    logic                o_ready_res;

    angle_scoreboard     scoreboard;
    bit                  tx_idle_en;
    bit                  rx_idle_en;
    logic [TIME_W-1:0]   rise_time;     // next rising edge of the synthetic PWM signal

    always #5 i_clk = ~i_clk;

    pwm_angle_decoder #(
        .COUNTER_WIDTH (COUNTER_WIDTH),
        .RESOLUTION    (RESOLUTION)
    ) DUT (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_wdata    (i_cfg_wdata),
        .i_in_valid     (i_in_valid),
        .o_in_ready     (o_in_ready),
        .i_capture_time (i_capture_time),
        .o_out_valid    (o_out_valid),
        .i_out_ready    (i_out_ready),
        .o_angle_centi  (o_angle_centi),
        .o_high_count   (o_high_count),
        .o_period_count (o_period_count),
        .o_ready_res    (o_ready_res)
    );

    // Offer one capture; valid stays up across back-to-back transactions and
    // drops only for a random gap, so it is never lowered and raised in one step.
    task automatic send_capture(input logic [TIME_W-1:0] cap);
        if (tx_idle_en && $urandom_range(0, 99) < 14) begin
            i_in_valid <= 1'b0;
            repeat ($urandom_range(1, 40)) @(posedge i_clk);
        end
        i_in_valid     <= 1'b1;
        i_capture_time <= cap;
        do @(posedge i_clk); while (!o_in_ready);
        scoreboard.note_capture(cap);
    endtask

    // Stop offering, let every owed reading come back, then let the block settle
    task automatic drain_results();
        i_in_valid <= 1'b0;
        while (scoreboard.pending() != 0) @(posedge i_clk);
        repeat (LATENCY + 8) @(posedge i_clk);
    endtask

    task automatic write_offset(input logic [ANGLE_W-1:0] value);
        drain_results();
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= value;
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
        scoreboard.set_offset(value);
    endtask

    // Mostly well-formed rise/fall pairs with random period and duty; the rest
    // are pairs of random timestamps. Pairs keep the edge parity aligned.
    task automatic send_random_items(input int unsigned count);
        int unsigned       sent;
        int unsigned       pick;
        logic [TIME_W-1:0] period;
        logic [TIME_W-1:0] high;
        sent = 0;
        while (sent < count) begin
            if ($urandom_range(0, 99) < 10) begin
                send_capture($urandom());
                send_capture($urandom());
            end else begin
                pick = $urandom_range(0, 99);
                if (pick < 70) begin
                    period = $urandom_range(100, 200000);
                end else if (pick < 85) begin
                    period = $urandom_range(0, 16);   // includes zero period
                end else begin
                    period = $urandom();
                end
                pick = $urandom_range(0, 99);
                if (pick < 80) begin
                    high = TIME_W'((64'(period) * $urandom_range(0, 1000)) / 1000);
                end else if (pick < 88) begin
                    high = period;
                end else if (pick < 94) begin
                    high = '0;
                end else begin
                    high = period + $urandom_range(1, 1000);   // high past period
                end
                send_capture(rise_time);
                send_capture(rise_time + high);
                rise_time = rise_time + period;
            end
            sent += 2;
        end
    endtask

    // Result side: check every transaction, idle at random, and once hold off
    // long enough for the block to back up into the capture channel.
    initial begin : result_sink
        int unsigned hold_left;
        int unsigned results_seen;
        hold_left    = 0;
        results_seen = 0;
        i_out_ready  = 1'b0;
        wait (i_rst_n === 1'b1);
        forever begin
            @(posedge i_clk);
            if (o_out_valid && i_out_ready) begin
                scoreboard.check_result(o_angle_centi, o_high_count, o_period_count,
                                        o_ready_res);
                results_seen++;
                if (results_seen == 300) begin
                    hold_left = 600;
                end
            end
            if (hold_left > 0) begin
                hold_left--;
                i_out_ready <= 1'b0;
            end else if (rx_idle_en && $urandom_range(0, 99) < 14) begin
                i_out_ready <= 1'b0;
            end else begin
                i_out_ready <= 1'b1;
            end
        end
    end

    initial begin : capture_source
        int unsigned        phase;
        logic [ANGLE_W-1:0] offset_value;
        scoreboard     = new();
        i_rst_n        = 1'b0;
        i_cfg_we       = 1'b0;
        i_cfg_wdata    = '0;
        i_in_valid     = 1'b0;
        i_capture_time = '0;
        tx_idle_en     = 1'b1;
        rx_idle_en     = 1'b1;
        rise_time      = $urandom();
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed edges under the reset offset
        foreach (DIRECTED_CAPS[k]) begin
            send_capture(DIRECTED_CAPS[k]);
        end

        // Random phases, each under its own offset; extremes first, and an
        // offset past one turn that must wrap. Phase 3 runs with no idling.
        for (phase = 0; phase < 8; phase++) begin
            unique case (phase)
                0: offset_value = 16'd0;
                1: offset_value = 16'd35999;
                2: offset_value = 16'd36000;
                3: offset_value = 16'd65535;
                4: offset_value = 16'd1;
                default: offset_value = ANGLE_W'($urandom_range(0, 65535));
            endcase
            write_offset(offset_value);
            tx_idle_en = (phase != 3);
            rx_idle_en = (phase != 3);
            send_random_items(200);
        end

        drain_results();
        if (scoreboard.mismatches == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

    // Watchdog, several times the slowest legal run
    initial begin : watchdog
        #10_000_000;
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
